// ===== rtl/core/glr_pkg.sv =====
// shared types and constants of the glyph rasterizer
package glr_pkg;

  // frame buffer geometry
  localparam int GLYPH_LINES    = 12;
  localparam int BYTES_PER_LINE = 18;
  localparam int WORDS_PER_LINE = 40;
  localparam int FONT_DEPTH     = 288;

  // address steps between glyph lines and between text rows
  localparam logic [12:0] LINE_STRIDE_B = 13'(BYTES_PER_LINE);
  localparam logic [12:0] LINE_STRIDE_W = 13'(WORDS_PER_LINE);
  localparam logic [12:0] ROW_STRIDE_B  = 13'(BYTES_PER_LINE * GLYPH_LINES);
  localparam logic [12:0] ROW_STRIDE_W  = 13'(WORDS_PER_LINE * GLYPH_LINES);

  // word target column offset
  localparam logic [12:0] WORD_COL_OFS = 13'd3;

  // kinds of twelve-line write jobs
  typedef enum logic [1:0] {
    JOB_PAIR   = 2'd0,
    JOB_BLARGE = 2'd1,
    JOB_WSMALL = 2'd2,
    JOB_WLARGE = 2'd3
  } job_kind_t;

  // one input character
  typedef struct packed {
    logic       kind;
    logic [3:0] row;
    logic [5:0] col;
    logic [6:0] code;
    logic       last;
  } item_t;

  // one glyph job: high and low glyph codes, start address
  typedef struct packed {
    job_kind_t   kind;
    logic [6:0]  hi_code;
    logic        hi_en;
    logic [6:0]  lo_code;
    logic        lo_en;
    logic [12:0] addr;
    logic        final_job;
  } job_t;

  // one write step handed to the font memory stage
  typedef struct packed {
    job_kind_t   kind;
    logic [8:0]  hi_idx;
    logic        hi_en;
    logic [8:0]  lo_idx;
    logic        lo_en;
    logic [1:0]  sel;
    logic        half;
    logic [12:0] addr;
    logic        last;
  } step_t;

endpackage

// ===== rtl/core/glr_seq.sv =====
// character decode, pending pair tracking and per-line write sequencer
module glr_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           target_mode,
  input  logic           in_valid,
  output logic           in_ready,
  input  glr_pkg::item_t item,
  input  logic           adv,
  output logic           step_valid,
  output glr_pkg::step_t step
);

  logic          busy;
  glr_pkg::job_t cur;
  glr_pkg::job_t queued;
  logic          queued_valid;
  logic [4:0]    step_cnt;
  logic [12:0]   line_addr;

  logic       pend_valid;
  logic [6:0] pend_code;
  logic [5:0] pend_col;
  logic [3:0] pend_row;

  logic          wide;
  logic [3:0]    line;
  logic          half;
  logic          line_end;
  logic          final_step;
  logic [12:0]   stride;
  logic          accept;
  logic          byte_small;
  logic          odd;
  logic          match;
  logic          stale_en;
  logic          main_en;
  logic [12:0]   row_base_b;
  logic [12:0]   row_base_w;
  glr_pkg::job_t stale_job;
  glr_pkg::job_t main_job;
  glr_pkg::job_t first_job;

  // font memory index of one glyph line
  function automatic logic [8:0] font_idx(input logic [6:0] code, input logic [1:0] quad);
    logic [6:0] ofs;
    begin
      ofs = code - 7'd32;
      font_idx = {2'b00, ofs} + {1'b0, ofs, 1'b0} + {7'd0, quad};
    end
  endfunction

  // step position within the current job
  always_comb begin
    wide       = (cur.kind == glr_pkg::JOB_WLARGE);
    line       = wide ? step_cnt[4:1] : step_cnt[3:0];
    half       = wide & step_cnt[0];
    line_end   = !wide | step_cnt[0];
    final_step = wide ? (step_cnt == 5'(2 * glr_pkg::GLYPH_LINES - 1))
                      : (step_cnt == 5'(glr_pkg::GLYPH_LINES - 1));
    stride     = (cur.kind == glr_pkg::JOB_PAIR || cur.kind == glr_pkg::JOB_BLARGE)
                 ? glr_pkg::LINE_STRIDE_B : glr_pkg::LINE_STRIDE_W;
  end

  assign in_ready = adv && (!busy || (final_step && !queued_valid));
  assign accept   = in_valid && in_ready;

  // decode of the incoming character into at most two jobs
  always_comb begin
    byte_small = !target_mode && !item.kind;
    odd        = item.col[0];
    match      = pend_valid && (pend_row == item.row) && (pend_col == {item.col[5:1], 1'b0});
    stale_en   = byte_small && pend_valid && !(odd && match);
    main_en    = !(byte_small && !odd && !item.last);
    row_base_b = 13'(item.row) * glr_pkg::ROW_STRIDE_B;
    row_base_w = 13'(item.row) * glr_pkg::ROW_STRIDE_W;

    stale_job           = '0;
    stale_job.kind      = glr_pkg::JOB_PAIR;
    stale_job.hi_code   = pend_code;
    stale_job.hi_en     = 1'b1;
    stale_job.addr      = 13'(pend_row) * glr_pkg::ROW_STRIDE_B + 13'(pend_col[5:1]);
    stale_job.final_job = !main_en;

    main_job           = '0;
    main_job.final_job = 1'b1;
    main_job.lo_code   = item.code;
    main_job.lo_en     = 1'b1;
    if (target_mode) begin
      if (item.kind) begin
        main_job.kind = glr_pkg::JOB_WLARGE;
        main_job.addr = row_base_w + 13'({item.col, 1'b0}) + glr_pkg::WORD_COL_OFS;
      end else begin
        main_job.kind = glr_pkg::JOB_WSMALL;
        main_job.addr = row_base_w + 13'(item.col) + glr_pkg::WORD_COL_OFS;
      end
    end else if (item.kind) begin
      main_job.kind = glr_pkg::JOB_BLARGE;
      main_job.addr = row_base_b + 13'(item.col);
    end else if (odd) begin
      main_job.kind    = glr_pkg::JOB_PAIR;
      main_job.hi_code = pend_code;
      main_job.hi_en   = match;
      main_job.addr    = row_base_b + 13'(item.col[5:1]);
    end else begin
      main_job.kind    = glr_pkg::JOB_PAIR;
      main_job.hi_code = item.code;
      main_job.hi_en   = 1'b1;
      main_job.lo_code = 7'd0;
      main_job.lo_en   = 1'b0;
      main_job.addr    = row_base_b + 13'(item.col[5:1]);
    end

    first_job = stale_en ? stale_job : main_job;
  end

  // job sequencer, a new character replaces the finished job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      queued_valid <= 1'b0;
      step_cnt     <= '0;
    end else if (accept) begin
      busy         <= stale_en || main_en;
      queued_valid <= stale_en && main_en;
      queued       <= main_job;
      cur          <= first_job;
      line_addr    <= first_job.addr;
      step_cnt     <= '0;
    end else if (busy && adv) begin
      if (final_step) begin
        if (queued_valid) begin
          cur          <= queued;
          line_addr    <= queued.addr;
          step_cnt     <= '0;
          queued_valid <= 1'b0;
        end else begin
          busy <= 1'b0;
        end
      end else begin
        step_cnt <= step_cnt + 5'd1;
        if (line_end) begin
          line_addr <= line_addr + stride;
        end
      end
    end
  end

  // pending even-column character for the byte target
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_code  <= '0;
      pend_col   <= '0;
      pend_row   <= '0;
    end else if (accept && byte_small) begin
      if (odd) begin
        pend_valid <= 1'b0;
      end else begin
        pend_valid <= !item.last;
        if (!item.last) begin
          pend_code <= item.code;
          pend_col  <= item.col;
          pend_row  <= item.row;
        end
      end
    end
  end

  // step handed to the font stage
  always_comb begin
    step_valid  = busy;
    step.kind   = cur.kind;
    step.hi_en  = cur.hi_en && (cur.hi_code[6:5] != 2'b00);
    step.lo_en  = cur.lo_en && (cur.lo_code[6:5] != 2'b00);
    step.hi_idx = step.hi_en ? font_idx(cur.hi_code, line[3:2]) : 9'd0;
    step.lo_idx = step.lo_en ? font_idx(cur.lo_code, line[3:2]) : 9'd0;
    step.sel    = line[1:0];
    step.half   = half;
    step.addr   = line_addr + 13'(half);
    step.last   = cur.final_job && final_step;
  end

endmodule

// ===== rtl/core/glr_raster.sv =====
// font memory read, pixel expansion and output register
module glr_raster (
  input  logic           clk,
  input  logic           rst,
  input  logic           step_valid,
  input  glr_pkg::step_t step,
  input  logic           out_ready,
  output logic           adv,
  output logic           out_valid,
  output logic [12:0]    out_addr,
  output logic [15:0]    out_data,
  output logic           out_last
);

  localparam logic [15:0] LARGE_LEFT  = 16'ha000;
  localparam logic [15:0] LARGE_RIGHT = 16'h00a0;

  // font for codes 32 to 127, three words of four 3-pixel lines each, top line first
  localparam logic [11:0] FONT [glr_pkg::FONT_DEPTH] = '{
    12'o0000, 12'o0000, 12'o0000, 12'o2222, 12'o2200, 12'o2200, 12'o5550, 12'o0000, 12'o0000,
    12'o1157, 12'o7557, 12'o7544, 12'o2275, 12'o4631, 12'o5722, 12'o4513, 12'o2264, 12'o5100,
    12'o2753, 12'o6555, 12'o7310, 12'o2222, 12'o2000, 12'o0000, 12'o1326, 12'o4444, 12'o6231,
    12'o4623, 12'o1111, 12'o3264, 12'o0055, 12'o2772, 12'o5500, 12'o0022, 12'o2772, 12'o2200,
    12'o0000, 12'o0002, 12'o2244, 12'o0000, 12'o0770, 12'o0000, 12'o0000, 12'o0002, 12'o2200,
    12'o1111, 12'o2222, 12'o4444, 12'o2755, 12'o5555, 12'o7600, 12'o2662, 12'o2222, 12'o2200,
    12'o6711, 12'o1364, 12'o7700, 12'o6711, 12'o2311, 12'o7600, 12'o1155, 12'o5771, 12'o1100,
    12'o7746, 12'o7111, 12'o7600, 12'o3746, 12'o7555, 12'o7200, 12'o7711, 12'o1222, 12'o2200,
    12'o2755, 12'o6355, 12'o7600, 12'o3755, 12'o5731, 12'o1100, 12'o0002, 12'o2202, 12'o2200,
    12'o0002, 12'o2202, 12'o2244, 12'o0112, 12'o2442, 12'o2110, 12'o0007, 12'o7007, 12'o7000,
    12'o0442, 12'o2112, 12'o2440, 12'o6711, 12'o3220, 12'o2200, 12'o2255, 12'o0220, 12'o5522,
    12'o3755, 12'o5775, 12'o5500, 12'o6755, 12'o6755, 12'o7600, 12'o3744, 12'o4444, 12'o7300,
    12'o6755, 12'o5555, 12'o7600, 12'o7744, 12'o6644, 12'o7700, 12'o7744, 12'o6644, 12'o4400,
    12'o3744, 12'o4555, 12'o7300, 12'o5555, 12'o7755, 12'o5500, 12'o7722, 12'o2222, 12'o7700,
    12'o1111, 12'o1111, 12'o7600, 12'o5557, 12'o6655, 12'o5500, 12'o4444, 12'o4444, 12'o7700,
    12'o5577, 12'o7555, 12'o5500, 12'o1155, 12'o7775, 12'o5400, 12'o2755, 12'o5555, 12'o7200,
    12'o6755, 12'o5764, 12'o4400, 12'o2755, 12'o5555, 12'o6310, 12'o6755, 12'o5675, 12'o5500,
    12'o3744, 12'o6311, 12'o7600, 12'o7722, 12'o2222, 12'o2200, 12'o5555, 12'o5555, 12'o7200,
    12'o5555, 12'o5577, 12'o2200, 12'o5555, 12'o5777, 12'o5500, 12'o5557, 12'o2275, 12'o5500,
    12'o5555, 12'o7722, 12'o2200, 12'o7711, 12'o3264, 12'o7700, 12'o3322, 12'o2222, 12'o2233,
    12'o4444, 12'o2222, 12'o1111, 12'o6622, 12'o2222, 12'o2266, 12'o2275, 12'o5000, 12'o0000,
    12'o0000, 12'o0000, 12'o0077, 12'o4462, 12'o2000, 12'o0000, 12'o0067, 12'o1375, 12'o7300,
    12'o4467, 12'o5555, 12'o7600, 12'o0037, 12'o4444, 12'o7300, 12'o1137, 12'o5555, 12'o7300,
    12'o0027, 12'o5764, 12'o7300, 12'o1322, 12'o7722, 12'o2200, 12'o0037, 12'o5557, 12'o3176,
    12'o4467, 12'o5555, 12'o5500, 12'o2202, 12'o2222, 12'o2200, 12'o2202, 12'o2222, 12'o2264,
    12'o4455, 12'o7665, 12'o5500, 12'o6622, 12'o2222, 12'o2200, 12'o0057, 12'o7755, 12'o5500,
    12'o0067, 12'o5555, 12'o5500, 12'o0027, 12'o5555, 12'o7200, 12'o0067, 12'o5555, 12'o7644,
    12'o0037, 12'o5555, 12'o7311, 12'o0057, 12'o6444, 12'o4400, 12'o0037, 12'o4631, 12'o7600,
    12'o2277, 12'o2222, 12'o3100, 12'o0055, 12'o5555, 12'o7300, 12'o0055, 12'o5557, 12'o2200,
    12'o0055, 12'o5577, 12'o7500, 12'o0055, 12'o7227, 12'o5500, 12'o0055, 12'o5557, 12'o3176,
    12'o0077, 12'o1224, 12'o7700, 12'o1322, 12'o2442, 12'o2231, 12'o2222, 12'o2222, 12'o2222,
    12'o4622, 12'o2112, 12'o2264, 12'o0000, 12'o1774, 12'o0000, 12'o0000, 12'o0000, 12'o0000
  };

  logic           s1_valid;
  glr_pkg::step_t s1;
  logic [11:0]    rom_hi;
  logic [11:0]    rom_lo;
  logic [2:0]     hi_bits;
  logic [2:0]     lo_bits;
  logic [15:0]    data;

  // one 3-pixel line out of a font word
  function automatic logic [2:0] pick(input logic [11:0] w, input logic [1:0] sel);
    begin
      case (sel)
        2'd0:    pick = w[11:9];
        2'd1:    pick = w[8:6];
        2'd2:    pick = w[5:3];
        default: pick = w[2:0];
      endcase
    end
  endfunction

  // whole pipe moves when the output register is free
  assign adv = !out_valid || out_ready;

  // pixel expansion for each job kind
  always_comb begin
    hi_bits = s1.hi_en ? pick(rom_hi, s1.sel) : 3'd0;
    lo_bits = s1.lo_en ? pick(rom_lo, s1.sel) : 3'd0;
    case (s1.kind)
      glr_pkg::JOB_PAIR: begin
        data = {9'd0, hi_bits, 1'b0, lo_bits};
      end
      glr_pkg::JOB_BLARGE: begin
        data = {10'd0, lo_bits[2], lo_bits[2], lo_bits[1], lo_bits[1], lo_bits[0], lo_bits[0]};
      end
      glr_pkg::JOB_WSMALL: begin
        data = {lo_bits[1], 1'b0, lo_bits[0], 7'd0, lo_bits[2], 5'd0};
      end
      glr_pkg::JOB_WLARGE: begin
        if (s1.half) begin
          data = (lo_bits[0] ? LARGE_LEFT : 16'd0) | (lo_bits[1] ? LARGE_RIGHT : 16'd0);
        end else begin
          data = lo_bits[2] ? LARGE_LEFT : 16'd0;
        end
      end
      default: begin
        data = 16'd0;
      end
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= step_valid;
      out_valid <= s1_valid;
    end
  end

  // font memory read and output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= step;
      rom_hi   <= FONT[step.hi_idx];
      rom_lo   <= FONT[step.lo_idx];
      out_addr <= s1.addr;
      out_data <= data;
      out_last <= s1.last;
    end
  end

endmodule

// ===== rtl/core/glyph_rasterizer.sv =====
// glyph rasterizer top level: config register, stream ports, sequencer and font stage
//
// One character enters per transfer on the s_axis side; each one turns into
// frame buffer writes (address and pixel data) on the m_axis side, tlast on
// the final write of that character. target_mode picks a byte buffer (two
// small glyphs packed per byte, large glyphs pixel-doubled) or a word buffer.
// An even-column small character on the byte target is held until the next
// small character; it is written with its odd partner, or alone if another
// small character comes first, and at once if it ends a string. Each job
// writes twelve glyph lines, two words per line for large text on the word
// target; a held character that must be flushed first adds a job of its own.
// The write sequencer issues one font memory read per cycle while m_axis does
// not stall. A new character is taken in the cycle that issues the last step
// of the previous one, so characters follow with no gap. The first write
// passes the sequencer job register, font memory read and output register.
// Reset clears target_mode, the held character and all valids. When m_axis
// stalls, the whole pipe holds and s_axis_tready drops.
module glyph_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // text_row[3:0], char_col[9:4], char_code[16:10], zero
  input  logic        s_axis_tuser,   // kind
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // write_addr[12:0], write_data[28:13], zero
  output logic        m_axis_tlast    // last_write
);

  logic           target_mode;
  glr_pkg::item_t item;
  logic           adv;
  logic           step_valid;
  glr_pkg::step_t step;
  logic [12:0]    out_addr;
  logic [15:0]    out_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      target_mode <= cfg_wr_data;
    end
  end

  // input fields
  always_comb begin
    item.kind = s_axis_tuser;
    item.row  = s_axis_tdata[3:0];
    item.col  = s_axis_tdata[9:4];
    item.code = s_axis_tdata[16:10];
    item.last = s_axis_tlast;
  end

  glr_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .target_mode (target_mode),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .item        (item),
    .adv         (adv),
    .step_valid  (step_valid),
    .step        (step)
  );

  glr_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step       (step),
    .out_ready  (m_axis_tready),
    .adv        (adv),
    .out_valid  (m_axis_tvalid),
    .out_addr   (out_addr),
    .out_data   (out_data),
    .out_last   (m_axis_tlast)
  );

  // output packing
  assign m_axis_tdata = {3'd0, out_data, out_addr};

endmodule
